/* design/fl64_pkg.sv */
// Shared constants for the Fletcher-64 slot checksum block.
`timescale 1ns / 1ps
`default_nettype none

package fl64_pkg;

  // Default block length limit, in words
  localparam int unsigned MaxWordsDefault = 65536;

  // Field widths
  localparam int unsigned WordW = 32;
  localparam int unsigned SlotW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSlotWordIndex = 1'b0;
  localparam logic [CfgIdxW-1:0] RegInsertMode    = 1'b1;

endpackage : fl64_pkg

`default_nettype wire

/* design/fletcher64_slot_checksum.sv */
// Fletcher-64 checksum over a streamed block of words, with a stored-checksum slot.
// Input channel: one 32-bit word per item (data_word_i) plus a last-word mark.
// An item is taken on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: one item per block, the 64-bit checksum (high sum above the
// low sum) and a flag that is 1 in insert mode or when the checksum matches
// the two slot words captured at slot_word_index. Slot words count as zero.
// Throughput: one word per cycle while in_stall_o is low, set by the single
// accumulate step of the two 32-bit sums held in registers. The result appears
// on the output register in the cycle after its last word is taken.
// The output register parts the two sides: words are still taken while a
// result waits, except when that result is held by out_stall_i, in which case
// in_stall_o is raised until it is taken.
// Configuration: cfg_we_i with cfg_index_i and cfg_wdata_i writes a register;
// write only between blocks.
// Reset clears both sums, the word position, the captured slot words, the
// configuration registers and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module fletcher64_slot_checksum #(
  parameter int unsigned MaxWords = fl64_pkg::MaxWordsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input words
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [fl64_pkg::WordW-1:0]         data_word_i,
  input  wire logic                               last_word_i,
  // results
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [2*fl64_pkg::WordW-1:0]            checksum_value_o,
  output logic                                    checksum_ok_o,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [fl64_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [fl64_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned WordW = fl64_pkg::WordW;
  localparam int unsigned SlotW = fl64_pkg::SlotW;
  // position must hold MaxWords + 1 (saturation point)
  localparam int unsigned PosW  = $clog2(MaxWords + 2);
  localparam int unsigned CmpW  = (PosW > SlotW + 1) ? PosW : SlotW + 1;
  localparam logic [PosW-1:0] PosMax = PosW'(MaxWords + 1);

  // configuration registers
  logic [SlotW-1:0] slot_q;
  logic             insert_q;

  // block state
  logic [WordW-1:0] low_q, low_d;
  logic [WordW-1:0] high_q, high_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [WordW-1:0] stored_lo_q, stored_lo_d;
  logic [WordW-1:0] stored_hi_q, stored_hi_d;

  // output register
  logic                 out_valid_q;
  logic [2*WordW-1:0]   csum_q;
  logic                 ok_q;

  logic             in_fire;
  logic             out_fire;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  slot_ext;
  logic [CmpW-1:0]  slot_next_ext;
  logic             at_slot_lo;
  logic             at_slot_hi;
  logic [2*WordW-1:0] csum_new;

  assign out_fire   = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // slot position compare
  assign pos_ext       = CmpW'(pos_q);
  assign slot_ext      = CmpW'(slot_q);
  assign slot_next_ext = slot_ext + CmpW'(1);
  assign at_slot_lo    = (pos_ext == slot_ext);
  assign at_slot_hi    = !at_slot_lo && (pos_ext == slot_next_ext);

  // accumulate one word
  always_comb begin
    low_d       = low_q;
    high_d      = high_q;
    stored_lo_d = stored_lo_q;
    stored_hi_d = stored_hi_q;
    if (at_slot_lo) begin
      stored_lo_d = data_word_i;
      // slot at the final word counts one extra zero word
      if (last_word_i) begin
        high_d = high_q + {low_q[WordW-2:0], 1'b0};
      end else begin
        high_d = high_q + low_q;
      end
    end else if (at_slot_hi) begin
      stored_hi_d = data_word_i;
      high_d      = high_q + low_q;
    end else begin
      low_d  = low_q + data_word_i;
      high_d = high_q + low_d;
    end
    pos_d = (pos_q < PosMax) ? pos_q + PosW'(1) : pos_q;
  end

  assign csum_new = {high_d, low_d};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      insert_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fl64_pkg::RegSlotWordIndex: slot_q   <= cfg_wdata_i[SlotW-1:0];
        fl64_pkg::RegInsertMode:    insert_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // block state, cleared after the last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= '0;
      pos_q       <= '0;
      stored_lo_q <= '0;
      stored_hi_q <= '0;
    end else if (in_fire) begin
      if (last_word_i) begin
        low_q       <= '0;
        high_q      <= '0;
        pos_q       <= '0;
        stored_lo_q <= '0;
        stored_hi_q <= '0;
      end else begin
        low_q       <= low_d;
        high_q      <= high_d;
        pos_q       <= pos_d;
        stored_lo_q <= stored_lo_d;
        stored_hi_q <= stored_hi_d;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && last_word_i) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_fire && last_word_i) begin
      csum_q <= csum_new;
      ok_q   <= insert_q || (csum_new == {stored_hi_d, stored_lo_d});
    end
  end

  assign out_valid_o      = out_valid_q;
  assign checksum_value_o = csum_q;
  assign checksum_ok_o    = ok_q;

`ifndef ASSERT_OFF
  // a last word always yields a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_word_i |=> out_valid_o)
    else $error("result missing after last word");

  // block state is cleared after a last word
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_word_i |=> pos_q == '0 && low_q == '0 && high_q == '0)
    else $error("block state not cleared after last word");

  // input only held back by a waiting, stalled result
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // insert mode always flags ok
  a_insert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_word_i && insert_q |=> checksum_ok_o)
    else $error("insert mode result not flagged ok");
`endif

endmodule : fletcher64_slot_checksum

`default_nettype wire
